// ===== design/gcc_pkg.sv =====
// Shared types and constants for the graph component and cycle counter.
package gcc_pkg;

  // Item class decided by the front end
  typedef enum logic [2:0] {
    KIND_NONE = 3'b001,
    KIND_EDGE = 3'b010,
    KIND_DROP = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] node_a;
    logic [7:0] node_b;
    logic       last_edge;
  } item_t;

  typedef struct packed {
    logic [7:0]  component_count;
    logic [10:0] cycle_count;
    logic        edge_error;
  } res_t;

  // Node walk marks
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_OPEN = 2'd1;
  localparam logic [1:0] MARK_DONE = 2'd2;

  localparam logic [10:0] CYC_MAX  = 11'd2047;
  localparam logic [7:0]  COMP_MAX = 8'd255;

endpackage

// ===== design/graph_component_cycle_counter.sv =====
// Top level: node count register, front queue, walk engine and result register.
//
//  channel | ports                                          | handshake
//  --------+------------------------------------------------+-------------------
//  input   | in_edge_valid in_node_a in_node_b in_last_edge | in_push / in_full
//  result  | out_component_count out_cycle_count            | out_pop / out_empty
//          | out_edge_error                                 |
//  config  | cfg_wdata (node_count)                         | cfg_we
//
// An edge is taken, classified and appended to two lists, each append a read
// and a write, plus a link write when the list has a tail. A two-entry queue
// in front absorbs bursts; an item without an edge is only taken and classified.
// The final item runs the walk: ROOT, RCHK per root check; TOP, NB per skipped
// neighbour entry; TOP, NB, MK per other entry; TOP, POP per node pop; all
// through registered memories with separate read and write ports. Reset is
// synchronous; list and mark valid bits clear at once, so no clearing pass is
// needed. A full result register stalls the walk at its end.
module graph_component_cycle_counter #(
  parameter int MAX_NODES = 255,
  parameter int MAX_EDGES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_edge_valid,
  input  logic [7:0]  in_node_a,
  input  logic [7:0]  in_node_b,
  input  logic        in_last_edge,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_component_count,
  output logic [10:0] out_cycle_count,
  output logic        out_edge_error,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import gcc_pkg::*;

  logic [7:0] node_count_r;
  item_t      q_item;
  logic       q_vld, q_take;
  logic       res_vld, out_empty_r;
  res_t       res, out_r;

  // Hold the node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 8'd1;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  gcc_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_edge_valid(in_edge_valid), .in_node_a(in_node_a),
    .in_node_b(in_node_b), .in_last_edge(in_last_edge),
    .node_count(node_count_r),
    .q_item(q_item), .q_vld(q_vld), .q_take(q_take)
  );

  gcc_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
    .clk(clk), .rst_n(rst_n),
    .node_count(node_count_r),
    .q_item(q_item), .q_vld(q_vld), .q_take(q_take),
    .res_rdy(out_empty_r), .res_vld(res_vld), .res(res)
  );

  // Hold one result item until popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_empty_r <= 1'b1;
    end else if (res_vld) begin
      out_empty_r <= 1'b0;
    end else if (out_pop) begin
      out_empty_r <= 1'b1;
    end
    if (res_vld) begin
      out_r <= res;
    end
  end

  assign out_empty           = out_empty_r;
  assign out_component_count = out_r.component_count;
  assign out_cycle_count     = out_r.cycle_count;
  assign out_edge_error      = out_r.edge_error;

endmodule

// ===== design/gcc_front.sv =====
// Input queue that accepts items and classifies their node ids.
module gcc_front #(
  parameter int MAX_NODES = 255
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  logic           in_edge_valid,
  input  logic [7:0]     in_node_a,
  input  logic [7:0]     in_node_b,
  input  logic           in_last_edge,
  input  logic [7:0]     node_count,
  output gcc_pkg::item_t q_item,
  output logic           q_vld,
  input  logic           q_take
);
  import gcc_pkg::*;

  localparam logic [16:0] NODE_CAP = 17'(MAX_NODES);

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [16:0] live_cnt;
  logic       bad_id;
  logic       do_push, do_pop;
  item_t      new_item;

  // Classify the incoming edge against the live node count
  always_comb begin
    live_cnt = ({9'd0, node_count} > NODE_CAP) ? NODE_CAP : {9'd0, node_count};
    bad_id = (in_node_a == 8'd0) || (in_node_b == 8'd0) ||
             ({9'd0, in_node_a} > live_cnt) || ({9'd0, in_node_b} > live_cnt);
    new_item.node_a    = in_node_a;
    new_item.node_b    = in_node_b;
    new_item.last_edge = in_last_edge;
    if (!in_edge_valid) begin
      new_item.kind = KIND_NONE;
    end else if (bad_id) begin
      new_item.kind = KIND_DROP;
    end else begin
      new_item.kind = KIND_EDGE;
    end
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_vld   = (cnt_r != 2'd0);
  assign q_item  = q_r[rp_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_take && q_vld;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Advance pointers and store items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
    end
    if (do_push) begin
      q_r[wp_r] <= new_item;
    end
  end

endmodule

// ===== design/gcc_back.sv =====
// Edge loader and depth-first walk engine with its list and stack memories.
module gcc_back #(
  parameter int MAX_NODES = 255,
  parameter int MAX_EDGES = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     node_count,
  input  gcc_pkg::item_t q_item,
  input  logic           q_vld,
  output logic           q_take,
  input  logic           res_rdy,
  output logic           res_vld,
  output gcc_pkg::res_t  res
);
  import gcc_pkg::*;

  localparam int CAP = 2 * MAX_EDGES;
  localparam int EW  = $clog2(CAP + 1);
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [16:0] NODE_CAP = 17'(MAX_NODES);
  localparam logic [EW-1:0] FILL_LIM = EW'(CAP - 2);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_LCHK = 12'b000000000010,
    ST_ARD  = 12'b000000000100,
    ST_AWR1 = 12'b000000001000,
    ST_AWR2 = 12'b000000010000,
    ST_ROOT = 12'b000000100000,
    ST_RCHK = 12'b000001000000,
    ST_TOP  = 12'b000010000000,
    ST_POP  = 12'b000100000000,
    ST_NB   = 12'b001000000000,
    ST_MK   = 12'b010000000000,
    ST_EMIT = 12'b100000000000
  } st_t;

  typedef struct packed {
    logic [7:0]    node;
    logic [EW-1:0] cursor;
    logic [7:0]    parent;
  } stk_t;

  // Control and walk registers
  st_t           st_r, st_nxt;
  item_t         it_r, it_nxt;
  logic [7:0]    own_r, own_nxt, val_r, val_nxt;
  logic          phase_r, phase_nxt;
  logic [EW-1:0] stored_r, stored_nxt, old_r, old_nxt, pos_r, pos_nxt;
  logic [10:0]   cyc_r, cyc_nxt;
  logic [7:0]    comp_r, comp_nxt;
  logic          drop_r, drop_nxt;
  logic [8:0]    root_r, root_nxt, depth_r, depth_nxt;
  logic [7:0]    cur_r, cur_nxt, par_r, par_nxt;
  logic [255:0]  lv_v_r, mk_v_r;
  logic          lv_hit_r, mk_hit_r;
  logic          clr_all;

  // Memory ports
  logic [7:0]    nid_mem [CAP];
  logic [EW-1:0] nlink_mem [CAP];
  logic [EW-1:0] lfirst_mem [256];
  logic [EW-1:0] llast_mem [256];
  logic [1:0]    mark_mem [256];
  stk_t          stk_mem [256];

  logic          nid_we, nlink_we, lfirst_we, llast_we, mark_we, stk_we;
  logic [AW-1:0] nid_wa, nlink_wa, ent_ra;
  logic [7:0]    nid_wd, lfirst_wa, llast_wa, mark_wa, stk_wa, stk_ra, nra;
  logic [EW-1:0] nlink_wd, lfirst_wd, llast_wd;
  logic [1:0]    mark_wd;
  stk_t          stk_wd;
  logic [7:0]    nid_q;
  logic [EW-1:0] nlink_q, lfirst_q, llast_q;
  logic [1:0]    mark_q;
  stk_t          stk_q;

  logic [16:0]   live_cnt;
  logic          app_done;
  logic          free_nb;

  assign live_cnt = ({9'd0, node_count} > NODE_CAP) ? NODE_CAP : {9'd0, node_count};
  assign res.component_count = comp_r;
  assign res.cycle_count     = cyc_r;
  assign res.edge_error      = drop_r;

  // Sequence the load and walk steps
  always_comb begin
    st_nxt = st_r;     it_nxt = it_r;       own_nxt = own_r;   val_nxt = val_r;
    phase_nxt = phase_r; stored_nxt = stored_r; old_nxt = old_r; pos_nxt = pos_r;
    cyc_nxt = cyc_r;   comp_nxt = comp_r;   drop_nxt = drop_r; root_nxt = root_r;
    depth_nxt = depth_r; cur_nxt = cur_r;   par_nxt = par_r;
    q_take = 1'b0; res_vld = 1'b0; clr_all = 1'b0; app_done = 1'b0;
    nid_we = 1'b0; nlink_we = 1'b0; lfirst_we = 1'b0; llast_we = 1'b0;
    mark_we = 1'b0; stk_we = 1'b0;
    nid_wa = AW'(stored_r); nid_wd = val_r;
    nlink_wa = AW'(stored_r); nlink_wd = '0;
    lfirst_wa = own_r; lfirst_wd = stored_r + EW'(1);
    llast_wa = own_r;  llast_wd = stored_r + EW'(1);
    mark_wa = cur_r; mark_wd = MARK_DONE;
    stk_wa = 8'(depth_r - 9'd1); stk_wd = '{node: cur_r, cursor: pos_r, parent: par_r};
    stk_ra = 8'(depth_r - 9'd2);
    ent_ra = AW'(pos_r - EW'(1));
    nra = root_r[7:0];
    free_nb = !mk_hit_r || (mark_q == MARK_FREE);

    unique case (st_r)
      ST_IDLE: begin
        if (q_vld) begin
          q_take = 1'b1;
          it_nxt = q_item;
          st_nxt = ST_LCHK;
        end
      end
      ST_LCHK: begin
        unique case (it_r.kind)
          KIND_EDGE: begin
            if (stored_r > FILL_LIM) begin
              drop_nxt = 1'b1;
              st_nxt = it_r.last_edge ? ST_ROOT : ST_IDLE;
            end else begin
              own_nxt = it_r.node_a;
              val_nxt = it_r.node_b;
              phase_nxt = 1'b0;
              st_nxt = ST_ARD;
            end
          end
          KIND_DROP: begin
            drop_nxt = 1'b1;
            st_nxt = it_r.last_edge ? ST_ROOT : ST_IDLE;
          end
          default: begin
            st_nxt = it_r.last_edge ? ST_ROOT : ST_IDLE;
          end
        endcase
        root_nxt = 9'd1;
      end
      ST_ARD: begin
        st_nxt = ST_AWR1;
      end
      ST_AWR1: begin
        nid_we = 1'b1;
        nlink_we = 1'b1;
        llast_we = 1'b1;
        lfirst_we = !lv_v_r[own_r];
        old_nxt = llast_q;
        stored_nxt = stored_r + EW'(1);
        if (lv_v_r[own_r]) begin
          st_nxt = ST_AWR2;
        end else begin
          app_done = 1'b1;
        end
      end
      ST_AWR2: begin
        nlink_we = 1'b1;
        nlink_wa = AW'(old_r - EW'(1));
        nlink_wd = stored_r;
        app_done = 1'b1;
      end
      ST_ROOT: begin
        if ({8'd0, root_r} > live_cnt) begin
          st_nxt = ST_EMIT;
        end else begin
          st_nxt = ST_RCHK;
        end
      end
      ST_RCHK: begin
        if (mk_hit_r && mark_q != MARK_FREE) begin
          root_nxt = root_r + 9'd1;
          st_nxt = ST_ROOT;
        end else begin
          if (comp_r != COMP_MAX) begin
            comp_nxt = comp_r + 8'd1;
          end
          cur_nxt = root_r[7:0];
          pos_nxt = lv_hit_r ? lfirst_q : '0;
          par_nxt = 8'd0;
          depth_nxt = 9'd1;
          mark_we = 1'b1;
          mark_wa = root_r[7:0];
          mark_wd = MARK_OPEN;
          st_nxt = ST_TOP;
        end
      end
      ST_TOP: begin
        if (pos_r == '0) begin
          mark_we = 1'b1;
          depth_nxt = depth_r - 9'd1;
          if (depth_r == 9'd1) begin
            root_nxt = root_r + 9'd1;
            st_nxt = ST_ROOT;
          end else begin
            st_nxt = ST_POP;
          end
        end else begin
          st_nxt = ST_NB;
        end
      end
      ST_POP: begin
        cur_nxt = stk_q.node;
        pos_nxt = stk_q.cursor;
        par_nxt = stk_q.parent;
        st_nxt = ST_TOP;
      end
      ST_NB: begin
        pos_nxt = nlink_q;
        val_nxt = nid_q;
        nra = nid_q;
        if (nid_q == 8'd0 || {9'd0, nid_q} > live_cnt || nid_q == cur_r) begin
          st_nxt = ST_TOP;
        end else begin
          st_nxt = ST_MK;
        end
      end
      ST_MK: begin
        if (free_nb) begin
          stk_we = 1'b1;
          cur_nxt = val_r;
          pos_nxt = lv_hit_r ? lfirst_q : '0;
          par_nxt = cur_r;
          depth_nxt = depth_r + 9'd1;
          mark_we = 1'b1;
          mark_wa = val_r;
          mark_wd = MARK_OPEN;
        end else if (mark_q == MARK_OPEN && (depth_r == 9'd1 || par_r != val_r)) begin
          if (cyc_r != CYC_MAX) begin
            cyc_nxt = cyc_r + 11'd1;
          end
        end
        st_nxt = ST_TOP;
      end
      ST_EMIT: begin
        if (res_rdy) begin
          res_vld = 1'b1;
          clr_all = 1'b1;
          stored_nxt = '0;
          cyc_nxt = '0;
          comp_nxt = '0;
          drop_nxt = 1'b0;
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // Finish one list append: second end next, or close the edge
    if (app_done) begin
      if (!phase_r) begin
        phase_nxt = 1'b1;
        own_nxt = it_r.node_b;
        val_nxt = it_r.node_a;
        st_nxt = ST_ARD;
      end else begin
        if (it_r.node_a == it_r.node_b && cyc_r != CYC_MAX) begin
          cyc_nxt = cyc_r + 11'd1;
        end
        st_nxt = it_r.last_edge ? ST_ROOT : ST_IDLE;
      end
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      stored_r <= '0;
      cyc_r <= '0;
      comp_r <= '0;
      drop_r <= 1'b0;
      depth_r <= '0;
      root_r <= 9'd1;
      lv_v_r <= '0;
      mk_v_r <= '0;
    end else begin
      st_r <= st_nxt;
      stored_r <= stored_nxt;
      cyc_r <= cyc_nxt;
      comp_r <= comp_nxt;
      drop_r <= drop_nxt;
      depth_r <= depth_nxt;
      root_r <= root_nxt;
      if (clr_all) begin
        lv_v_r <= '0;
        mk_v_r <= '0;
      end else begin
        if (llast_we) begin
          lv_v_r[llast_wa] <= 1'b1;
        end
        if (mark_we) begin
          mk_v_r[mark_wa] <= 1'b1;
        end
      end
    end
    it_r <= it_nxt;
    own_r <= own_nxt;
    val_r <= val_nxt;
    phase_r <= phase_nxt;
    old_r <= old_nxt;
    pos_r <= pos_nxt;
    cur_r <= cur_nxt;
    par_r <= par_nxt;
    lv_hit_r <= lv_v_r[nra];
    mk_hit_r <= mk_v_r[nra];
  end

  // Neighbour entry memories
  always_ff @(posedge clk) begin
    if (nid_we) begin
      nid_mem[nid_wa] <= nid_wd;
    end
    nid_q <= nid_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (nlink_we) begin
      nlink_mem[nlink_wa] <= nlink_wd;
    end
    nlink_q <= nlink_mem[ent_ra];
  end

  // List head and tail memories
  always_ff @(posedge clk) begin
    if (lfirst_we) begin
      lfirst_mem[lfirst_wa] <= lfirst_wd;
    end
    lfirst_q <= lfirst_mem[nra];
  end

  always_ff @(posedge clk) begin
    if (llast_we) begin
      llast_mem[llast_wa] <= llast_wd;
    end
    llast_q <= llast_mem[own_r];
  end

  // Node mark memory
  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    mark_q <= mark_mem[nra];
  end

  // Walk stack below the cached top entry
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_ra];
  end

endmodule
